// ----- src/acfr_pkg.sv -----
// ----------------------------------------------------------------------------
// acfr_pkg - AT command frame receiver package
// Shared types, phase and status codes, and default configuration values.
// ----------------------------------------------------------------------------
package acfr_pkg;

  // Counter width for stored and received byte counts
  localparam int unsigned CNT_W = 9;

  // Default buffer depth
  localparam int unsigned BUFFER_DEPTH_DEF = 256;

  // APB register map
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0]  REG_HEAD_PATTERN = 2'd0;
  localparam logic [1:0]  REG_END_PATTERN  = 2'd1;
  localparam logic [1:0]  REG_MAX_LENGTH   = 2'd2;

  // Register reset values
  localparam logic [15:0] HEAD_PATTERN_RST = 16'h4154;  // "AT"
  localparam logic [15:0] END_PATTERN_RST  = 16'h0D0A;  // CR LF
  localparam logic [7:0]  MAX_LENGTH_RST   = 8'hFF;

  // Receiver phases
  localparam logic [2:0] PH_HEAD   = 3'd0;
  localparam logic [2:0] PH_BODY   = 3'd1;
  localparam logic [2:0] PH_BRACED = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_COLLECT  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Brace characters
  localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             store_valid;
    logic [7:0]       store_index;
    logic [7:0]       store_byte;
    logic [CNT_W-1:0] frame_length;
    logic [CNT_W-1:0] bytes_received;
    logic [1:0]       error_phase;
  } out_t;

  typedef struct packed {
    logic [15:0] head_pattern;
    logic [15:0] end_pattern;
    logic [7:0]  max_length;
  } cfg_t;

endpackage

// ----- src/acfr_cfg.sv -----
// ----------------------------------------------------------------------------
// acfr_cfg - configuration registers
// APB-style register file holding head pattern, end pattern and max length.
// ----------------------------------------------------------------------------
module acfr_cfg
  import acfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [15:0] head_pattern_r, head_pattern_nxt;
  logic [15:0] end_pattern_r,  end_pattern_nxt;
  logic [7:0]  max_length_r,   max_length_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    head_pattern_nxt = head_pattern_r;
    end_pattern_nxt  = end_pattern_r;
    max_length_nxt   = max_length_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HEAD_PATTERN: head_pattern_nxt = pwdata[15:0];
        REG_END_PATTERN:  end_pattern_nxt  = pwdata[15:0];
        REG_MAX_LENGTH:   max_length_nxt   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_pattern_r <= HEAD_PATTERN_RST;
      end_pattern_r  <= END_PATTERN_RST;
      max_length_r   <= MAX_LENGTH_RST;
    end else begin
      head_pattern_r <= head_pattern_nxt;
      end_pattern_r  <= end_pattern_nxt;
      max_length_r   <= max_length_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAD_PATTERN: prdata = {16'd0, head_pattern_r};
      REG_END_PATTERN:  prdata = {16'd0, end_pattern_r};
      REG_MAX_LENGTH:   prdata = {24'd0, max_length_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.head_pattern = head_pattern_r;
  assign cfg.end_pattern  = end_pattern_r;
  assign cfg.max_length   = max_length_r;

endmodule

// ----- src/acfr_core.sv -----
// ----------------------------------------------------------------------------
// acfr_core - frame receiver state and per-byte update
// Holds phase, shift registers and counts; computes one result per step.
// ----------------------------------------------------------------------------
module acfr_core
  import acfr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t result
);

  localparam int unsigned DEPTH_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_W   = (DEPTH_W > CNT_W) ? DEPTH_W : CNT_W;
  localparam logic [CMP_W-1:0] DEPTH_LIM = CMP_W'(BUFFER_DEPTH);

  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      head_shift_r, head_shift_nxt;
  logic [15:0]      end_shift_r, end_shift_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [CNT_W-1:0] recv_r, recv_nxt;

  logic [15:0]      head_cat;
  logic [15:0]      end_cat;
  logic [CMP_W-1:0] stored_ext;
  logic             overflow;

  assign head_cat   = {head_shift_r[7:0], item.rx_byte};
  assign end_cat    = {end_shift_r[7:0], item.rx_byte};
  assign stored_ext = CMP_W'(stored_r);
  assign overflow   = (stored_r > {1'b0, cfg.max_length}) || (stored_ext >= DEPTH_LIM);

  always_comb begin
    phase_nxt      = phase_r;
    head_shift_nxt = head_shift_r;
    end_shift_nxt  = end_shift_r;
    stored_nxt     = stored_r;
    recv_nxt       = recv_r;

    result             = '0;
    result.status      = ST_COLLECT;

    if (item.opcode == OP_CLEAR) begin
      phase_nxt      = PH_HEAD;
      head_shift_nxt = '0;
      end_shift_nxt  = '0;
      stored_nxt     = '0;
      recv_nxt       = '0;
    end else if (phase_r == PH_HEAD) begin
      head_shift_nxt = head_cat;
      if (head_cat == cfg.head_pattern) begin
        phase_nxt     = PH_BODY;
        recv_nxt      = CNT_W'(2);
        stored_nxt    = '0;
        end_shift_nxt = '0;
      end
    end else if (phase_r >= PH_DONE) begin
      result.status = ST_REJECT;
    end else if (overflow) begin
      // abort: report phase, clear like a clear item
      result.status      = ST_OVERFLOW;
      result.error_phase = phase_r[1:0];
      phase_nxt      = PH_HEAD;
      head_shift_nxt = '0;
      end_shift_nxt  = '0;
      stored_nxt     = '0;
      recv_nxt       = '0;
    end else begin
      result.store_valid = 1'b1;
      result.store_index = stored_r[7:0];
      result.store_byte  = item.rx_byte;
      stored_nxt = stored_r + CNT_W'(1);
      recv_nxt   = recv_r + CNT_W'(1);
      if (phase_r == PH_BRACED) begin
        if (item.rx_byte == CH_CLOSE_BRACE) phase_nxt = PH_TAIL;
      end else begin
        if (phase_r == PH_BODY && item.rx_byte == CH_OPEN_BRACE) phase_nxt = PH_BRACED;
        end_shift_nxt = end_cat;
        // end match wins over an opening brace on the same byte
        if (end_cat == cfg.end_pattern) begin
          phase_nxt     = PH_DONE;
          result.status = ST_COMPLETE;
        end
      end
    end

    result.frame_length   = stored_nxt;
    result.bytes_received = recv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD;
      head_shift_r <= '0;
      end_shift_r  <= '0;
      stored_r     <= '0;
      recv_r       <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      head_shift_r <= head_shift_nxt;
      end_shift_r  <= end_shift_nxt;
      stored_r     <= stored_nxt;
      recv_r       <= recv_nxt;
    end
  end

endmodule

// ----- src/at_command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// at_command_frame_receiver - AT command frame receiver
// Per-byte frame assembly: head search, body, braced section, end match.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per received byte (opcode 0) or clear (opcode 1).
//           A transaction completes at a clock edge with in_valid high and
//           in_stall low.
//   out_* : exactly one result transaction per input transaction, in order.
//   APB   : head_pattern at 0x0, end_pattern at 0x4, max_length at 0x8.
//           Write only while no transaction is in flight; pready is tied high.
// Path: a taken byte is held in the input register; its result is computed
//   from there and captured in the result register, which drives out_data.
// Throughput: one byte per cycle unless out_stall holds a result; the frame state
//   update is a single combinational pass from input register to result register.
// Stall: when out_stall holds a pending result, the input register still
//   takes a byte if it is empty; once both are full, in_stall rises in the
//   same cycle and stays up until the result is taken.
// Reset: synchronous, active low; registers return to "AT" / CR LF / 255,
//   the receiver goes to head search with all counts zero, both stages empty.
// ----------------------------------------------------------------------------
module at_command_frame_receiver
  import acfr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  out_t result;

  // input stage
  logic in_valid_r;
  in_t  in_data_r;
  // result stage
  logic out_valid_r;
  out_t out_data_r;

  logic adv;  // item in input register moves to result register

  assign adv      = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~adv;

  acfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acfr_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // input side only backs up when the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("in_stall raised with empty input register");

  // overflow never stores and leaves zero counts
  a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OVERFLOW) |->
      (!out_data.store_valid && out_data.frame_length == '0 &&
       out_data.bytes_received == '0))
    else $error("overflow result stored a byte or kept counts");

  // stored byte count trails received count by the two head bytes
  a_count_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.store_valid) |->
      (out_data.bytes_received == out_data.frame_length + CNT_W'(2)))
    else $error("received count out of step with stored count");

  // frame completion only happens on a stored byte
  a_complete_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_COMPLETE) |-> out_data.store_valid)
    else $error("frame completed without storing the byte");

endmodule
